[src/sss_pkg.sv]
// ----------------------------------------------------------------------------
// sss_pkg
// Shared types and constants of the staged sleep sequencer: device status
// codes, operation codes, register indexes and the result record.
// ----------------------------------------------------------------------------
package sss_pkg;

    localparam int NORMAL_DEVICES = 4;
    localparam int MASK_W         = 5;
    localparam int CNT_W          = 3;
    localparam int CFG_ADDR_W     = 2;
    localparam int CFG_DATA_W     = 3;

    typedef enum logic [1:0] {
        ST_AWAKE   = 2'd0,
        ST_STARTED = 2'd1,
        ST_DONE    = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        OP_POLL    = 3'd0,
        OP_REQUEST = 3'd1,
        OP_CANCEL  = 3'd2,
        OP_DONE    = 3'd3,
        OP_START   = 3'd4,
        OP_STOP    = 3'd5,
        OP_WAKE    = 3'd6
    } t_op;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_EARLY_PRESENT = 2'd0,
        CFG_NORMAL_COUNT  = 2'd1,
        CFG_SLEEP_MODE    = 2'd2
    } t_cfg_addr;

    typedef struct packed {
        logic [MASK_W-1:0] sleep_mask;
        logic [1:0]        sleep_mode_out;
        logic [MASK_W-1:0] resume_mask;
        logic              resume_timeup;
        logic              system_sleep;
        logic              request_pending;
    } t_result;

    function automatic logic [CNT_W-1:0] f_active(input logic [CNT_W-1:0] count);
        if (int'(count) > NORMAL_DEVICES) begin
            return CNT_W'(NORMAL_DEVICES);
        end
        return count;
    endfunction

endpackage

[src/sss_core.sv]
// ----------------------------------------------------------------------------
// sss_core
// Sequencer state, configuration registers and the combinational next-state
// and result logic for one request.
// ----------------------------------------------------------------------------
module sss_core
    import sss_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_accept,
    input  logic [2:0]            i_op,
    input  logic [31:0]           i_now,
    input  logic [31:0]           i_delay,
    input  logic [2:0]            i_device,
    input  logic                  i_rtc_timeup,
    output t_result               o_result
);

    logic              r_early_present, n_early_present;
    logic [CNT_W-1:0]  r_normal_count,  n_normal_count;
    logic [1:0]        r_sleep_mode,    n_sleep_mode;
    logic              r_started,       n_started;
    logic              r_request_flag,  n_request_flag;
    logic [31:0]       r_deadline,      n_deadline;
    t_status           r_early_status,  n_early_status;
    t_status           r_normal_status [NORMAL_DEVICES];
    t_status           n_normal_status [NORMAL_DEVICES];

    logic [32:0]       sum;
    logic [31:0]       target;
    logic [CNT_W-1:0]  act_n;
    logic [CNT_W-1:0]  new_n;
    logic [MASK_W-1:0] enabled_mask;

    assign sum    = {1'b0, i_now} + {1'b0, i_delay};
    assign target = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    assign act_n  = f_active(r_normal_count);
    assign new_n  = f_active(i_cfg_wdata);

    always_comb begin
        enabled_mask    = '0;
        enabled_mask[0] = r_early_present;
        for (int i = 0; i < NORMAL_DEVICES; i++) begin
            if (i < int'(act_n)) begin
                enabled_mask[i+1] = 1'b1;
            end
        end
    end

    always_comb begin
        logic              all_done;
        logic [MASK_W-1:0] smask;
        logic [MASK_W-1:0] rmask;
        logic              rtime;
        logic              ssleep;
        all_done        = 1'b1;
        smask           = '0;
        rmask           = '0;
        rtime           = 1'b0;
        ssleep          = 1'b0;
        n_early_present = r_early_present;
        n_normal_count  = r_normal_count;
        n_sleep_mode    = r_sleep_mode;
        n_started       = r_started;
        n_request_flag  = r_request_flag;
        n_deadline      = r_deadline;
        n_early_status  = r_early_status;
        n_normal_status = r_normal_status;

        if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_EARLY_PRESENT: begin
                    if (i_cfg_wdata[0] && !r_early_present) begin
                        n_early_status = ST_AWAKE;
                    end
                    n_early_present = i_cfg_wdata[0];
                end
                CFG_NORMAL_COUNT: begin
                    n_normal_count = i_cfg_wdata;
                    for (int i = 0; i < NORMAL_DEVICES; i++) begin
                        if (i >= int'(act_n) && i < int'(new_n)) begin
                            n_normal_status[i] = ST_AWAKE;
                        end
                    end
                end
                CFG_SLEEP_MODE: begin
                    n_sleep_mode = i_cfg_wdata[1:0];
                end
                default: begin
                end
            endcase
        end

        if (i_accept) begin
            case (t_op'(i_op))
                OP_POLL: begin
                    if (r_started && r_request_flag && i_now > r_deadline) begin
                        if (r_early_present && r_early_status != ST_DONE) begin
                            if (r_early_status == ST_AWAKE) begin
                                n_early_status = ST_STARTED;
                                smask[0]       = 1'b1;
                            end
                        end else begin
                            for (int i = 0; i < NORMAL_DEVICES; i++) begin
                                if (i < int'(act_n)) begin
                                    if (r_normal_status[i] == ST_AWAKE) begin
                                        n_normal_status[i] = ST_STARTED;
                                        smask[i+1]         = 1'b1;
                                    end
                                    if (r_normal_status[i] != ST_DONE) begin
                                        all_done = 1'b0;
                                    end
                                end
                            end
                            if (all_done) begin
                                n_request_flag = 1'b0;
                                ssleep         = 1'b1;
                            end
                        end
                    end
                end
                OP_REQUEST: begin
                    if (r_started) begin
                        n_request_flag = 1'b1;
                        if (target > r_deadline) begin
                            n_deadline = target;
                        end
                    end
                end
                OP_CANCEL: begin
                    n_request_flag = 1'b0;
                end
                OP_DONE: begin
                    if (i_device == 3'd0) begin
                        if (r_early_present) begin
                            n_early_status = ST_DONE;
                        end
                    end else begin
                        for (int i = 0; i < NORMAL_DEVICES; i++) begin
                            if (i < int'(act_n) && int'(i_device) == i + 1) begin
                                n_normal_status[i] = ST_DONE;
                            end
                        end
                    end
                end
                OP_START, OP_WAKE: begin
                    if (t_op'(i_op) == OP_START) begin
                        n_started = 1'b1;
                        rtime     = 1'b1;
                    end else begin
                        rtime     = i_rtc_timeup;
                    end
                    rmask = enabled_mask;
                    if (r_early_present) begin
                        n_early_status = ST_AWAKE;
                    end
                    for (int i = 0; i < NORMAL_DEVICES; i++) begin
                        if (i < int'(act_n)) begin
                            n_normal_status[i] = ST_AWAKE;
                        end
                    end
                end
                OP_STOP: begin
                    n_started = 1'b0;
                end
                default: begin
                end
            endcase
        end

        o_result.sleep_mask      = smask;
        o_result.sleep_mode_out  = (|smask) ? r_sleep_mode : 2'd0;
        o_result.resume_mask     = rmask;
        o_result.resume_timeup   = rtime;
        o_result.system_sleep    = ssleep;
        o_result.request_pending = n_request_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_early_present <= 1'b0;
            r_normal_count  <= '0;
            r_sleep_mode    <= '0;
            r_started       <= 1'b0;
            r_request_flag  <= 1'b0;
            r_deadline      <= '0;
            r_early_status  <= ST_AWAKE;
            for (int i = 0; i < NORMAL_DEVICES; i++) begin
                r_normal_status[i] <= ST_AWAKE;
            end
        end else begin
            r_early_present <= n_early_present;
            r_normal_count  <= n_normal_count;
            r_sleep_mode    <= n_sleep_mode;
            r_started       <= n_started;
            r_request_flag  <= n_request_flag;
            r_deadline      <= n_deadline;
            r_early_status  <= n_early_status;
            r_normal_status <= n_normal_status;
        end
    end

endmodule

[src/sss_out_reg.sv]
// ----------------------------------------------------------------------------
// sss_out_reg
// Result register with valid/ready hand-off; loads a new result in the same
// cycle that the held one is taken.
// ----------------------------------------------------------------------------
module sss_out_reg
    import sss_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_out_ready,
    output logic    o_can_load,
    output logic    o_out_valid,
    output t_result o_result
);

    logic    r_valid, n_valid;
    t_result r_result;

    assign o_can_load  = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_result    = r_result;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

[src/staged_sleep_sequencer_top.sv]
// ----------------------------------------------------------------------------
// staged_sleep_sequencer_top
// Sleep-handshake sequencer for one early device and four normal devices.
// ----------------------------------------------------------------------------
// Each request is decoded and applied to the sequencer state in the cycle it
// is accepted, and its result appears in the output register on the next
// cycle; one request per cycle is sustained while results are taken. The
// input side stays ready while a result waits, as long as that result is
// taken in the same cycle; the single result register is what limits
// throughput when the output stalls. Configuration writes are registered:
// a request accepted with one sees the old setting. They carry no handshake.
// ----------------------------------------------------------------------------
module staged_sleep_sequencer_top
    import sss_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [2:0]            i_op,
    input  logic [31:0]           i_now,
    input  logic [31:0]           i_delay,
    input  logic [2:0]            i_device,
    input  logic                  i_rtc_timeup,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [MASK_W-1:0]     o_sleep_mask,
    output logic [1:0]            o_sleep_mode_out,
    output logic [MASK_W-1:0]     o_resume_mask,
    output logic                  o_resume_timeup,
    output logic                  o_system_sleep,
    output logic                  o_request_pending
);

    logic    accept;
    t_result core_result;
    t_result out_result;

    assign accept = i_in_valid && o_in_ready;

    sss_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_accept     (accept),
        .i_op         (i_op),
        .i_now        (i_now),
        .i_delay      (i_delay),
        .i_device     (i_device),
        .i_rtc_timeup (i_rtc_timeup),
        .o_result     (core_result)
    );

    sss_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_result    (core_result),
        .i_out_ready (i_out_ready),
        .o_can_load  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_result    (out_result)
    );

    assign o_sleep_mask      = out_result.sleep_mask;
    assign o_sleep_mode_out  = out_result.sleep_mode_out;
    assign o_resume_mask     = out_result.resume_mask;
    assign o_resume_timeup   = out_result.resume_timeup;
    assign o_system_sleep    = out_result.system_sleep;
    assign o_request_pending = out_result.request_pending;

    a_sleep_clears_request: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_system_sleep) |-> !o_request_pending
    ) else $error("system sleep with request still pending");

    a_no_sleep_and_resume: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_sleep_mask == '0 || o_resume_mask == '0)
    ) else $error("sleep and resume commands in one result");

    a_mode_only_with_sleep: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_sleep_mask == '0) |-> (o_sleep_mode_out == 2'd0)
    ) else $error("sleep mode without sleep command");

    a_accept_gives_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_out_valid
    ) else $error("accepted request produced no result");

endmodule
